// File: hdl/sbe_pkg.sv
// ----------------------------------------------------------------------------
// sbe_pkg
// Shared types for the stereo band exciter: payload words and divider links.
// ----------------------------------------------------------------------------
package sbe_pkg;

  typedef struct packed {
    logic signed [15:0] left_in;
    logic signed [15:0] right_in;
  } in_word_t;

  typedef struct packed {
    logic signed [15:0] left_out;
    logic signed [15:0] right_out;
  } out_word_t;

  localparam int unsigned DivNumW = 56;
  localparam int unsigned DivDenW = 26;

  typedef struct packed {
    logic               start;
    logic [DivNumW-1:0] num;
    logic [DivDenW-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic               busy;
    logic               done;
    logic [DivNumW-1:0] quot;
  } div_rsp_t;

endpackage

// File: hdl/sbe_div.sv
// ----------------------------------------------------------------------------
// sbe_div
// Serial restoring divider, one quotient bit per cycle, unsigned operands.
// ----------------------------------------------------------------------------
module sbe_div (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  sbe_pkg::div_req_t req_i,
  output sbe_pkg::div_rsp_t rsp_o
);
  import sbe_pkg::*;

  localparam int unsigned CntW = $clog2(DivNumW + 1);

  logic               busy_q;
  logic               done_q;
  logic [CntW-1:0]    cnt_q;
  logic [DivNumW-1:0] quot_q;
  logic [DivDenW-1:0] rem_q;
  logic [DivDenW-1:0] den_q;
  logic [DivDenW:0]   rem_sh;
  logic [DivDenW:0]   rem_sub;

  assign rem_sh  = {rem_q, quot_q[DivNumW-1]};
  assign rem_sub = rem_sh - {1'b0, den_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start && !busy_q) begin
        busy_q <= 1'b1;
        cnt_q  <= CntW'(DivNumW);
      end else if (busy_q) begin
        cnt_q <= cnt_q - CntW'(1);
        if (cnt_q == CntW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start && !busy_q) begin
      quot_q <= req_i.num;
      rem_q  <= '0;
      den_q  <= req_i.den;
    end else if (busy_q) begin
      if (!rem_sub[DivDenW]) begin
        rem_q  <= rem_sub[DivDenW-1:0];
        quot_q <= {quot_q[DivNumW-2:0], 1'b1};
      end else begin
        rem_q  <= rem_sh[DivDenW-1:0];
        quot_q <= {quot_q[DivNumW-2:0], 1'b0};
      end
    end
  end

  assign rsp_o.busy = busy_q;
  assign rsp_o.done = done_q;
  assign rsp_o.quot = quot_q;

endmodule

// File: hdl/stereo_band_exciter_unit.sv
// ----------------------------------------------------------------------------
// stereo_band_exciter_unit
// High-frequency exciter for one stereo pair per word, built around a shared
// multiplier and a serial divider under a small sequencer.
// ----------------------------------------------------------------------------
// Each word uses the serial divider five times; no new word is taken until the
// last one is handed to the output register. After reset the whole ring buffer
// is cleared before the first word is taken. The user must write configuration
// only while no word is in flight; the block itself does not enforce this.
module stereo_band_exciter_unit #(
  parameter int RING_WORDS      = 400,
  parameter int HIGHPASS_STAGES = 4
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [1:0]         cfg_idx_i,
  input  logic [6:0]         cfg_data_i,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  sbe_pkg::in_word_t  in_word_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output sbe_pkg::out_word_t out_word_o
);
  import sbe_pkg::*;

  localparam int unsigned RingAw = $clog2(RING_WORDS);
  localparam int unsigned StW    = $clog2(HIGHPASS_STAGES + 1);
  localparam logic [RingAw:0]   RingLen  = (RingAw + 1)'(RING_WORDS);
  localparam logic [RingAw-1:0] RingLast = RingAw'(RING_WORDS - 1);
  localparam logic [RingAw-1:0] RingInit = RingAw'(RING_WORDS - 8);
  localparam logic [StW-1:0]    LastK    = StW'(HIGHPASS_STAGES - 1);

  localparam logic [1:0] CfgSel = 2'd0;
  localparam logic [1:0] CfgLvl = 2'd1;

  localparam logic [4:0] StClear = 5'd0;
  localparam logic [4:0] StIdle  = 5'd1;
  localparam logic [4:0] StHp    = 5'd2;
  localparam logic [4:0] StWrL   = 5'd3;
  localparam logic [4:0] StWrR   = 5'd4;
  localparam logic [4:0] StRd    = 5'd5;
  localparam logic [4:0] StShift = 5'd6;
  localparam logic [4:0] StDvGo  = 5'd7;
  localparam logic [4:0] StDvWt  = 5'd8;
  localparam logic [4:0] StPeak  = 5'd9;
  localparam logic [4:0] StPkUp  = 5'd10;
  localparam logic [4:0] StPkDn  = 5'd11;
  localparam logic [4:0] StAmp   = 5'd12;
  localparam logic [4:0] StEng   = 5'd13;
  localparam logic [4:0] StSfGo  = 5'd14;
  localparam logic [4:0] StSfWt  = 5'd15;
  localparam logic [4:0] StMul   = 5'd16;
  localparam logic [4:0] StWtGo  = 5'd17;
  localparam logic [4:0] StWtWt  = 5'd18;
  localparam logic [4:0] StOut   = 5'd19;
  localparam logic [4:0] StDone  = 5'd20;

  function automatic logic [21:0] clamp_lvl(input logic signed [31:0] v);
    logic [21:0] r;
    if (v < 0) r = '0;
    else if (v > 32'sd2097152) r = 22'd2097152;
    else r = v[21:0];
    return r;
  endfunction

  logic [4:0]   state_q;
  logic [2:0]   sel_q;
  logic [6:0]   lvl_q;
  logic         ch_q;
  logic [StW-1:0] k_q;
  logic [2:0]   j_q;
  logic [RingAw-1:0] clr_q, wp_q, rp_q, rd_addr_q;
  logic         phase_q;

  logic signed [31:0] hist_q [2][HIGHPASS_STAGES];
  logic signed [31:0] peak_up_q [2];
  logic signed [31:0] peak_dn_q [2];
  logic signed [31:0] amp_q [2];
  logic signed [31:0] eng_q [2];

  logic signed [31:0] x_q [2];
  logic signed [31:0] p_q [2];
  logic signed [31:0] pick_q [2];
  logic signed [31:0] sh_q [2];
  logic signed [31:0] w_q [4];
  logic signed [31:0] cur_q;
  logic signed [32:0] cand_up_q, cand_dn_q;
  logic [22:0]        sf_q;
  logic signed [57:0] prod_q;
  logic               neg_q;
  logic signed [37:0] wt_q;
  logic [25:0]        divisor_q;
  logic signed [15:0] res_q [2];
  out_word_t          out_word_q;
  logic               out_valid_q;
  logic               out_valid_d;

  logic [31:0] ring_mem [RING_WORDS];
  logic [31:0] rdata_q;
  logic              mem_we;
  logic [RingAw-1:0] mem_addr;
  logic [31:0]       mem_wdata;

  logic signed [33:0] mul_a;
  logic signed [23:0] mul_b;
  logic signed [57:0] prod;

  div_req_t div_req;
  div_rsp_t div_rsp;

  logic [6:0]   lvl_eff;
  logic [21:0]  a_c, e_c;
  logic [RingAw:0] base_sum, rp8_sum;
  logic signed [32:0] pk_t, trk_v;
  logic signed [36:0] pk_t16;
  logic [32:0]  trk_mag;
  logic signed [33:0] trk_sum;
  logic [27:0]  sf_sum;
  logic signed [37:0] out_sum;
  logic signed [29:0] out_y;
  logic signed [15:0] out_sat;
  logic signed [31:0] hp_new;
  logic signed [31:0] in_x;

  sbe_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  assign lvl_eff = (lvl_q > 7'd101) ? 7'd101 : lvl_q;
  assign a_c     = clamp_lvl(amp_q[ch_q]);
  assign e_c     = clamp_lvl(eng_q[ch_q]);
  assign hp_new  = prod[47:16];
  assign in_x    = {{8{in_word_i.left_in[15]}}, in_word_i.left_in, 8'd0};

  always_comb begin
    base_sum = {1'b0, rp_q} + (phase_q ? (RingAw + 1)'(0) : (RingAw + 1)'(4));
    if (base_sum >= RingLen) base_sum = base_sum - RingLen;
    rp8_sum = {1'b0, rp_q} + (RingAw + 1)'(8);
    if (rp8_sum >= RingLen) rp8_sum = rp8_sum - RingLen;
  end

  always_comb begin
    pk_t    = 33'(x_q[ch_q]) + 33'(p_q[ch_q]);
    pk_t16  = 37'(pk_t) <<< 4;
    if (state_q == StAmp) trk_v = 33'(peak_up_q[ch_q]) - 33'(peak_dn_q[ch_q]);
    else trk_v = 33'(x_q[ch_q]) - 33'(p_q[ch_q]);
    trk_mag = trk_v[32] ? 33'(-trk_v) : 33'(trk_v);
    if (state_q == StAmp) trk_sum = 34'(amp_q[ch_q]) + 34'(trk_mag >> 3);
    else trk_sum = 34'(eng_q[ch_q]) + 34'(trk_mag >> 3);
    sf_sum  = 28'(div_rsp.quot[26:0]) + 28'(e_c);
    out_sum = 38'(x_q[ch_q]) + wt_q;
    out_y   = out_sum[37:8];
    if (out_y > 30'sd32767) out_sat = 16'sh7fff;
    else if (out_y < -30'sd32768) out_sat = -16'sh8000;
    else out_sat = out_y[15:0];
  end

  // shared multiplier
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_q)
      StHp: begin
        mul_a = 34'(cur_q) - 34'(hist_q[ch_q][0]);
        mul_b = 24'sd56880;
      end
      StPkUp: begin
        mul_a = 34'(cand_up_q);
        mul_b = 24'sd1000;
      end
      StPkDn: begin
        mul_a = 34'(cand_dn_q);
        mul_b = 24'sd1000;
      end
      StAmp, StEng: begin
        mul_a = trk_sum;
        mul_b = 24'sd120;
      end
      StMul: begin
        mul_a = 34'(sh_q[ch_q]);
        mul_b = {1'b0, sf_q};
      end
      default: ;
    endcase
  end

  assign prod = 58'(mul_a) * 58'(mul_b);

  always_comb begin
    div_req = '0;
    case (state_q)
      StDvGo: begin
        div_req.start = 1'b1;
        div_req.num   = DivNumW'(41943040);
        div_req.den   = DivDenW'(lvl_eff) + DivDenW'(1);
      end
      StSfGo: begin
        div_req.start = 1'b1;
        div_req.num   = {13'd0, 23'(e_c) + 23'd128000, 20'd0};
        div_req.den   = DivDenW'(a_c) + DivDenW'(76800);
      end
      StWtGo: begin
        div_req.start = 1'b1;
        div_req.num   = neg_q ? 56'(-prod_q) : 56'(prod_q);
        div_req.den   = divisor_q;
      end
      default: ;
    endcase
  end

  always_comb begin
    mem_we    = 1'b0;
    mem_addr  = rd_addr_q;
    mem_wdata = '0;
    case (state_q)
      StClear: begin
        mem_we   = 1'b1;
        mem_addr = clr_q;
      end
      StWrL: begin
        mem_we    = 1'b1;
        mem_addr  = wp_q;
        mem_wdata = pick_q[0];
      end
      StWrR: begin
        mem_we    = 1'b1;
        mem_addr  = wp_q;
        mem_wdata = pick_q[1];
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) ring_mem[mem_addr] <= mem_wdata;
    rdata_q <= ring_mem[mem_addr];
  end

  // output word handshake
  always_comb begin
    out_valid_d = out_valid_q;
    if (out_valid_q && !out_stall_i) out_valid_d = 1'b0;
    if (state_q == StDone && (!out_valid_q || !out_stall_i)) out_valid_d = 1'b1;
  end

  // config registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sel_q <= 3'd3;
      lvl_q <= 7'd28;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CfgSel:  sel_q <= cfg_data_i[2:0];
        CfgLvl:  lvl_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // sequencer and tracked state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StClear;
      ch_q        <= 1'b0;
      k_q         <= '0;
      j_q         <= '0;
      clr_q       <= '0;
      wp_q        <= RingInit;
      rp_q        <= RingInit;
      rd_addr_q   <= '0;
      phase_q     <= 1'b0;
      out_valid_q <= 1'b0;
      for (int c = 0; c < 2; c++) begin
        for (int i = 0; i < HIGHPASS_STAGES; i++) hist_q[c][i] <= '0;
        peak_up_q[c] <= '0;
        peak_dn_q[c] <= '0;
        amp_q[c]     <= '0;
        eng_q[c]     <= '0;
      end
    end else begin
      out_valid_q <= out_valid_d;
      case (state_q)
        StClear: begin
          clr_q <= clr_q + RingAw'(1);
          if (clr_q == RingLast) state_q <= StIdle;
        end
        StIdle: begin
          if (in_valid_i) begin
            ch_q    <= 1'b0;
            k_q     <= '0;
            state_q <= StHp;
          end
        end
        StHp: begin
          for (int c = 0; c < 2; c++) begin
            if (c == int'(ch_q)) begin
              for (int i = 0; i < HIGHPASS_STAGES - 1; i++) hist_q[c][i] <= hist_q[c][i + 1];
              hist_q[c][HIGHPASS_STAGES - 1] <= cur_q;
            end
          end
          if (k_q == LastK) begin
            k_q <= '0;
            if (ch_q) begin
              ch_q    <= 1'b0;
              state_q <= StWrL;
            end else begin
              ch_q <= 1'b1;
            end
          end else begin
            k_q <= k_q + StW'(1);
          end
        end
        StWrL: begin
          wp_q    <= (wp_q == RingLast) ? '0 : wp_q + RingAw'(1);
          state_q <= StWrR;
        end
        StWrR: begin
          wp_q      <= (wp_q == RingLast) ? '0 : wp_q + RingAw'(1);
          rd_addr_q <= base_sum[RingAw-1:0];
          j_q       <= '0;
          state_q   <= StRd;
        end
        StRd: begin
          j_q       <= j_q + 3'd1;
          rd_addr_q <= (rd_addr_q == RingLast) ? '0 : rd_addr_q + RingAw'(1);
          if (j_q == 3'd4) state_q <= StShift;
        end
        StShift: begin
          if (!phase_q) begin
            rp_q    <= rp8_sum[RingAw-1:0];
            phase_q <= 1'b1;
          end else begin
            phase_q <= 1'b0;
          end
          state_q <= StDvGo;
        end
        StDvGo:  state_q <= StDvWt;
        StDvWt:  if (div_rsp.done) state_q <= StPeak;
        StPeak:  state_q <= StPkUp;
        StPkUp: begin
          peak_up_q[ch_q] <= prod[41:10];
          state_q         <= StPkDn;
        end
        StPkDn: begin
          peak_dn_q[ch_q] <= prod[41:10];
          state_q         <= StAmp;
        end
        StAmp: begin
          amp_q[ch_q] <= prod[38:7];
          state_q     <= StEng;
        end
        StEng: begin
          eng_q[ch_q] <= prod[38:7];
          state_q     <= StSfGo;
        end
        StSfGo:  state_q <= StSfWt;
        StSfWt:  if (div_rsp.done) state_q <= StMul;
        StMul:   state_q <= StWtGo;
        StWtGo:  state_q <= StWtWt;
        StWtWt:  if (div_rsp.done) state_q <= StOut;
        StOut: begin
          if (ch_q) begin
            ch_q    <= 1'b0;
            state_q <= StDone;
          end else begin
            ch_q    <= 1'b1;
            state_q <= StPeak;
          end
        end
        StDone: begin
          if (!out_valid_q || !out_stall_i) begin
            state_q <= StIdle;
          end
        end
        default: state_q <= StIdle;
      endcase
    end
  end

  // datapath words
  always_ff @(posedge clk_i) begin
    case (state_q)
      StIdle: begin
        x_q[0] <= in_x;
        x_q[1] <= {{8{in_word_i.right_in[15]}}, in_word_i.right_in, 8'd0};
        cur_q  <= in_x;
      end
      StHp: begin
        if (k_q == '0) p_q[ch_q] <= hist_q[ch_q][0];
        if (int'(k_q) == int'(sel_q)) pick_q[ch_q] <= cur_q;
        if (k_q == LastK) begin
          if (int'(sel_q) >= HIGHPASS_STAGES) pick_q[ch_q] <= hp_new;
          cur_q <= x_q[1];
        end else begin
          cur_q <= hp_new;
        end
      end
      StRd: begin
        if (j_q != 3'd0) begin
          w_q[3] <= rdata_q;
          for (int i = 0; i < 3; i++) w_q[i] <= w_q[i + 1];
        end
      end
      StShift: begin
        sh_q[0] <= 32'((34'(w_q[0]) <<< 1) + 34'(w_q[2]) >>> 2);
        sh_q[1] <= 32'((34'(w_q[1]) <<< 1) + 34'(w_q[3]) >>> 2);
      end
      StDvWt: begin
        if (div_rsp.done) divisor_q <= div_rsp.quot[25:0] + {4'd0, 7'd102 - lvl_eff, 15'd0};
      end
      StPeak: begin
        cand_up_q <= (pk_t16 > 37'(peak_up_q[ch_q])) ? pk_t : 33'(peak_up_q[ch_q]);
        cand_dn_q <= (!(pk_t16 > 37'(peak_up_q[ch_q])) && (pk_t16 < 37'(peak_dn_q[ch_q])))
                     ? pk_t : 33'(peak_dn_q[ch_q]);
      end
      StSfWt: begin
        if (div_rsp.done) sf_q <= (sf_sum > 28'd4194304) ? 23'd4194304 : sf_sum[22:0];
      end
      StMul: begin
        prod_q <= prod;
        neg_q  <= prod[57];
      end
      StWtWt: begin
        if (div_rsp.done) wt_q <= neg_q ? -$signed(div_rsp.quot[37:0]) : $signed(div_rsp.quot[37:0]);
      end
      StOut: res_q[ch_q] <= out_sat;
      StDone: begin
        if (!out_valid_q || !out_stall_i) begin
          out_word_q.left_out  <= res_q[0];
          out_word_q.right_out <= res_q[1];
        end
      end
      default: ;
    endcase
  end

  assign in_stall_o  = (state_q != StIdle);
  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_word_q;

  a_wp_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    int'(wp_q) < RING_WORDS)
    else $error("ring write position out of range");

  a_rp_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    int'(rp_q) < RING_WORDS)
    else $error("ring read position out of range");

  a_div_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_req.start |-> !div_rsp.busy)
    else $error("divider started while busy");

  a_phase: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StShift) |=> (phase_q != $past(phase_q)))
    else $error("shift phase did not toggle");

endmodule
